### hw/rtl/ppmp_pkg.sv
// ----------------------------------------------------------------------------
// ppmp_pkg
// Shared types and character codes for the P3 pixel parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmp_pkg;

  localparam logic [7:0] CH_HASH    = 8'd35;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_NINE    = 8'd57;

  localparam int unsigned HDR_W    = 16;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned TDATA_W  = HDR_W + 3 * CHAN_W;

  typedef enum logic [2:0] {
    KIND_WIDTH      = 3'd0,
    KIND_HEIGHT     = 3'd1,
    KIND_MAX_VALUE  = 3'd2,
    KIND_PIXEL      = 3'd3,
    KIND_BAD_HEADER = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_SKIP   = 4'b0001,
    PH_HEADER = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [HDR_W-1:0]  header_value;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last_pixel;
  } result_t;

  typedef struct packed {
    logic done;
    logic in_comment;
    logic in_number;
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/ppm_ascii_pixel_parser_core.sv
// ----------------------------------------------------------------------------
// ppm_ascii_pixel_parser_core
// Plain-text PPM (P3) parser: header numbers and RGB pixels from a byte stream.
// ----------------------------------------------------------------------------
// Takes one character per cycle whenever the result register is free or being
// drained (in_tready = !out_tvalid | out_tready), so a stream with a ready sink
// runs at one byte per clock. A result appears on the master side in the cycle
// after the byte that ends its number; the only stage is the parser state plus
// the result register. The first line is dropped, '#' comments run to newline,
// header values saturate at 2^DIM_BITS-1, pixel channels keep their low 8 bits,
// and after the last pixel all bytes are consumed without results until reset.
`default_nettype none

module ppm_ascii_pixel_parser_core
  import ppmp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [15:0] header_value, [23:16] red,
                                              // [31:24] green, [39:32] blue
  output logic [2:0]              out_tuser,  // [2:0] kind
  output logic                    out_tlast   // last_pixel
);

  result_t res;
  status_t status;
  logic    accept;
  logic    can_load;

  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  ppmp_parser #(
    .DIM_BITS(DIM_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(accept),
    .byte_in   (in_tdata),
    .res       (res),
    .status    (status)
  );

  ppmp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .load      (accept),
    .can_load  (can_load),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |-> !res.valid)
    else $error("result produced after last pixel");

  a_header_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != KIND_PIXEL)) |->
      (!out_tlast && (out_tdata[TDATA_W-1:HDR_W] == '0)))
    else $error("header result carries pixel fields");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && res.valid && res.last_pixel) |=> status.done)
    else $error("last pixel did not end the image");

  a_comment_no_number: assert property (@(posedge clk) disable iff (!rst_n)
    !(status.in_comment && status.in_number))
    else $error("number still open inside a comment");

endmodule

`default_nettype wire

### hw/rtl/ppmp_parser.sv
// ----------------------------------------------------------------------------
// ppmp_parser
// Parser state and per-byte next-state logic; yields at most one result.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmp_parser
  import ppmp_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_valid,
  input  wire logic [7:0] byte_in,
  output result_t         res,
  output status_t         status
);

  localparam int unsigned SUM_W = DIM_BITS + 4;
  localparam int unsigned CNT_W = 2 * DIM_BITS;
  localparam logic [SUM_W-1:0] HDR_MAX = SUM_W'({DIM_BITS{1'b1}});

  phase_t              phase_r, phase_nxt;
  logic                in_comment_r, in_comment_nxt;
  logic                in_number_r, in_number_nxt;
  logic [DIM_BITS-1:0] acc_r, acc_nxt;
  logic [1:0]          field_r, field_nxt;
  logic [CHAN_W-1:0]   held_red_r, held_red_nxt;
  logic [CHAN_W-1:0]   held_green_r, held_green_nxt;
  logic [DIM_BITS-1:0] width_r, width_nxt;
  logic [DIM_BITS-1:0] height_r, height_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    total_r;

  logic              is_digit;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count_inc;

  assign is_digit  = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign sum       = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0}
                   + SUM_W'(byte_in - CH_ZERO);
  assign count_inc = count_r + CNT_W'(1);

  always_comb begin
    phase_nxt      = phase_r;
    in_comment_nxt = in_comment_r;
    in_number_nxt  = in_number_r;
    acc_nxt        = acc_r;
    field_nxt      = field_r;
    held_red_nxt   = held_red_r;
    held_green_nxt = held_green_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    count_nxt      = count_r;
    res            = '0;
    if (byte_valid) begin
      unique case (phase_r)
        PH_SKIP: begin
          if (byte_in == CH_NEWLINE) begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER, PH_PIXELS: begin
          if (in_comment_r) begin
            if (byte_in == CH_NEWLINE) begin
              in_comment_nxt = 1'b0;
            end
          end else if (is_digit) begin
            in_number_nxt = 1'b1;
            if (phase_r == PH_HEADER) begin
              acc_nxt = (sum > HDR_MAX) ? DIM_BITS'(HDR_MAX) : sum[DIM_BITS-1:0];
            end else begin
              acc_nxt = DIM_BITS'(sum[CHAN_W-1:0]);
            end
          end else begin
            if (in_number_r) begin
              acc_nxt       = '0;
              in_number_nxt = 1'b0;
              if (phase_r == PH_HEADER) begin
                res.valid        = 1'b1;
                res.header_value = HDR_W'(acc_r);
                unique case (field_r)
                  2'd0: begin
                    width_nxt = acc_r;
                    field_nxt = 2'd1;
                    res.kind  = KIND_WIDTH;
                  end
                  2'd1: begin
                    height_nxt = acc_r;
                    field_nxt  = 2'd2;
                    res.kind   = KIND_HEIGHT;
                  end
                  default: begin
                    field_nxt = 2'd0;
                    if ((width_r == '0) || (height_r == '0)) begin
                      res.kind         = KIND_BAD_HEADER;
                      res.header_value = '0;
                    end else begin
                      res.kind  = KIND_MAX_VALUE;
                      phase_nxt = PH_PIXELS;
                      count_nxt = '0;
                    end
                  end
                endcase
              end else begin
                unique case (field_r)
                  2'd0: begin
                    held_red_nxt = acc_r[CHAN_W-1:0];
                    field_nxt    = 2'd1;
                  end
                  2'd1: begin
                    held_green_nxt = acc_r[CHAN_W-1:0];
                    field_nxt      = 2'd2;
                  end
                  default: begin
                    field_nxt      = 2'd0;
                    count_nxt      = count_inc;
                    res.valid      = 1'b1;
                    res.kind       = KIND_PIXEL;
                    res.red        = held_red_r;
                    res.green      = held_green_r;
                    res.blue       = acc_r[CHAN_W-1:0];
                    res.last_pixel = (count_inc == total_r);
                    if (count_inc == total_r) begin
                      phase_nxt = PH_DONE;
                    end
                  end
                endcase
              end
            end
            if ((byte_in == CH_HASH) && (phase_nxt != PH_DONE)) begin
              in_comment_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SKIP;
      in_comment_r <= 1'b0;
      in_number_r  <= 1'b0;
      acc_r        <= '0;
      field_r      <= '0;
      held_red_r   <= '0;
      held_green_r <= '0;
      width_r      <= '0;
      height_r     <= '0;
      count_r      <= '0;
    end else begin
      phase_r      <= phase_nxt;
      in_comment_r <= in_comment_nxt;
      in_number_r  <= in_number_nxt;
      acc_r        <= acc_nxt;
      field_r      <= field_nxt;
      held_red_r   <= held_red_nxt;
      held_green_r <= held_green_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      count_r      <= count_nxt;
    end
  end

  // product settles long before the first pixel completes
  always_ff @(posedge clk) begin
    total_r <= CNT_W'(width_r) * CNT_W'(height_r);
  end

  assign status.done       = (phase_r == PH_DONE);
  assign status.in_comment = in_comment_r;
  assign status.in_number  = in_number_r;

endmodule

`default_nettype wire

### hw/rtl/ppmp_out_reg.sv
// ----------------------------------------------------------------------------
// ppmp_out_reg
// Result register on the master side; holds a result until its transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmp_out_reg
  import ppmp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  result_t                 res,
  input  wire logic               load,
  output logic                    can_load,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,
  output logic [2:0]              out_tuser,
  output logic                    out_tlast
);

  logic    valid_r, valid_nxt;
  result_t data_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load && res.valid) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      data_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.blue, data_r.green, data_r.red, data_r.header_value};
  assign out_tuser  = data_r.kind;
  assign out_tlast  = data_r.last_pixel;

endmodule

`default_nettype wire
